/* src/afe_pkg.sv */
// ----------------------------------------------------------------------------
// Audio fade envelope package
// Widths, register indices, region codes and the structures that travel
// between the pipeline sections of the fade envelope unit.
// ----------------------------------------------------------------------------
package afe_pkg;

	localparam int FRAME_BITS     = 20;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int SAMPLE_W       = 16;
	localparam int POS_W          = 16;
	localparam int LEN_W          = 9;
	localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
	localparam int PROD_W         = LEN_W + POS_W;
	localparam int NUM_W          = PROD_W + 1;
	localparam int APB_AW         = 5;
	localparam int APB_DW         = 32;

	localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
	localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;

	typedef enum logic [2:0] {
		REGION_OUTSIDE  = 3'd0,
		REGION_MUTED    = 3'd1,
		REGION_FADE_IN  = 3'd2,
		REGION_FADE_OUT = 3'd3,
		REGION_UNITY    = 3'd4
	} region_t;

	typedef enum logic [2:0] {
		REG_SELECT_START = 3'd0,
		REG_SELECT_END   = 3'd1,
		REG_FADE_IN      = 3'd2,
		REG_FADE_OUT     = 3'd3,
		REG_SILENT_HEAD  = 3'd4,
		REG_SILENT_TAIL  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] select_start;
		logic [FRAME_BITS-1:0] select_end;
		logic [LEN_W-1:0]      fade_in_frames;
		logic [LEN_W-1:0]      fade_out_frames;
		logic [LEN_W-1:0]      silent_head_frames;
		logic [LEN_W-1:0]      silent_tail_frames;
	} afe_cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		region_t                    region;
	} afe_tag_t;

	typedef struct packed {
		afe_tag_t         tag;
		logic             sat;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
	} afe_div_in_t;

	typedef struct packed {
		afe_tag_t                  tag;
		logic                      sat;
		logic [GAIN_FRAC_BITS-1:0] quot;
	} afe_div_out_t;

endpackage

/* src/audio_fade_envelope_unit.sv */
// ----------------------------------------------------------------------------
// Audio fade envelope unit
// Applies a linear fade-in and fade-out envelope over a selected frame range
// of a 16-bit audio sample stream, with silent margins at either end.
// ----------------------------------------------------------------------------
// The unit accepts one item in every clock cycle unless back-pressure from
// the output has filled the pipeline, and delivers one result per item, in
// order. The gain divider resolves one of the 16 gain fraction bits per
// pipeline stage; three front-end stages classify the frame and form the
// gain ratio, and two back-end stages apply the gain.
// Back-pressure is handled stage by stage, so empty stages keep filling
// while the output waits. The registers are written through the APB port and
// should be changed only while no items are in flight.
module audio_fade_envelope_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [afe_pkg::APB_AW-1:0]           paddr,
	input  logic [afe_pkg::APB_DW-1:0]           pwdata,
	output logic [afe_pkg::APB_DW-1:0]           prdata,
	output logic                                 pready,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic [afe_pkg::FRAME_BITS-1:0]       frame_number,
	input  logic [afe_pkg::POS_W-1:0]            sample_position,
	input  logic [afe_pkg::POS_W-1:0]            samples_per_frame,
	input  logic signed [afe_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [afe_pkg::SAMPLE_W-1:0]  sample_out,
	output logic [2:0]                           region
);
	import afe_pkg::*;

	afe_cfg_t     cfg_q;
	reg_idx_t     reg_idx;
	logic         cfg_wr;
	logic         div_in_valid, div_in_ready, div_out_valid, div_out_ready;
	afe_div_in_t  div_in;
	afe_div_out_t div_out;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SELECT_START: cfg_q.select_start       <= pwdata[FRAME_BITS-1:0];
				REG_SELECT_END:   cfg_q.select_end         <= pwdata[FRAME_BITS-1:0];
				REG_FADE_IN:      cfg_q.fade_in_frames     <= pwdata[LEN_W-1:0];
				REG_FADE_OUT:     cfg_q.fade_out_frames    <= pwdata[LEN_W-1:0];
				REG_SILENT_HEAD:  cfg_q.silent_head_frames <= pwdata[LEN_W-1:0];
				REG_SILENT_TAIL:  cfg_q.silent_tail_frames <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SELECT_START: prdata = APB_DW'(cfg_q.select_start);
			REG_SELECT_END:   prdata = APB_DW'(cfg_q.select_end);
			REG_FADE_IN:      prdata = APB_DW'(cfg_q.fade_in_frames);
			REG_FADE_OUT:     prdata = APB_DW'(cfg_q.fade_out_frames);
			REG_SILENT_HEAD:  prdata = APB_DW'(cfg_q.silent_head_frames);
			REG_SILENT_TAIL:  prdata = APB_DW'(cfg_q.silent_tail_frames);
			default:          prdata = '0;
		endcase
	end

	afe_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.in_valid          (item_valid),
		.in_ready          (item_ready),
		.frame_number      (frame_number),
		.sample_position   (sample_position),
		.samples_per_frame (samples_per_frame),
		.sample_in         (sample_in),
		.out_valid         (div_in_valid),
		.out_ready         (div_in_ready),
		.out_data          (div_in)
	);

	afe_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_in_valid),
		.in_ready  (div_in_ready),
		.in_data   (div_in),
		.out_valid (div_out_valid),
		.out_ready (div_out_ready),
		.out_data  (div_out)
	);

	afe_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (div_out_valid),
		.in_ready   (div_out_ready),
		.in_data    (div_out),
		.out_valid  (result_valid),
		.out_ready  (result_ready),
		.sample_out (sample_out),
		.region     (region)
	);

endmodule

/* src/afe_front.sv */
// ----------------------------------------------------------------------------
// Audio fade envelope front end
// Classifies each item by frame, then forms the numerator and denominator
// of the gain ratio over three pipeline stages.
// ----------------------------------------------------------------------------
module afe_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  afe_pkg::afe_cfg_t                     cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [afe_pkg::FRAME_BITS-1:0]        frame_number,
	input  logic [afe_pkg::POS_W-1:0]             sample_position,
	input  logic [afe_pkg::POS_W-1:0]             samples_per_frame,
	input  logic signed [afe_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output afe_pkg::afe_div_in_t                  out_data
);
	import afe_pkg::*;

	localparam int CMP_W = FRAME_BITS + 2;

	logic                     n_zero;
	logic [POS_W-1:0]         n_c, pos_c;
	logic signed [CMP_W-1:0]  frame_x, st_x, en_x, fade_st, fade_ed, d_in, d_out;
	logic                     outside, muted, in_fade, out_fade;
	region_t                  region_c;
	logic [LEN_W-1:0]         k_c, f_c;

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     rdy_s1, rdy_s2, rdy_s3;
	afe_tag_t                 tag_s1, tag_s2, tag_s3;
	logic [LEN_W-1:0]         k_s1, f_s1;
	logic [POS_W-1:0]         n_s1, pos_s1;
	logic [PROD_W-1:0]        kn_c, fn_c;
	logic [NUM_W-1:0]         used_s2, den_s2;
	logic [NUM_W-1:0]         num_c, num_s3, den_s3;
	logic                     sat_c, sat_s3;

	assign n_zero = (samples_per_frame == '0);
	assign n_c    = n_zero ? POS_W'(1) : samples_per_frame;
	assign pos_c  = n_zero ? '0 : sample_position;

	assign frame_x = signed'(CMP_W'(frame_number));
	assign st_x    = signed'(CMP_W'(cfg.select_start));
	assign en_x    = signed'(CMP_W'(cfg.select_end));
	assign fade_st = st_x + signed'(CMP_W'(cfg.silent_head_frames));
	assign fade_ed = en_x - signed'(CMP_W'(cfg.silent_tail_frames));
	assign d_in    = frame_x - fade_st;
	assign d_out   = fade_ed - frame_x;

	assign outside  = (frame_x < st_x) || (en_x < frame_x);
	assign muted    = (frame_x < fade_st) || (fade_ed < frame_x);
	assign in_fade  = d_in < signed'(CMP_W'(cfg.fade_in_frames));
	assign out_fade = d_out < signed'(CMP_W'(cfg.fade_out_frames));

	always_comb begin
		region_c = REGION_UNITY;
		k_c      = '0;
		f_c      = cfg.fade_out_frames;
		if (outside) begin
			region_c = REGION_OUTSIDE;
		end else if (muted) begin
			region_c = REGION_MUTED;
		end else if (in_fade) begin
			region_c = REGION_FADE_IN;
			k_c      = d_in[LEN_W-1:0];
			f_c      = cfg.fade_in_frames;
		end else if (out_fade) begin
			region_c = REGION_FADE_OUT;
			k_c      = cfg.fade_out_frames - d_out[LEN_W-1:0] - LEN_W'(1);
		end
	end

	assign rdy_s3   = !valid_s3 || out_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	assign kn_c = k_s1 * n_s1;
	assign fn_c = f_s1 * n_s1;

	always_comb begin
		num_c = '0;
		sat_c = 1'b0;
		if (tag_s2.region == REGION_FADE_IN) begin
			num_c = used_s2;
			sat_c = (used_s2 >= den_s2);
		end else if (tag_s2.region == REGION_FADE_OUT) begin
			num_c = (used_s2 >= den_s2) ? '0 : den_s2 - used_s2;
			sat_c = (used_s2 == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			tag_s1.sample <= sample_in;
			tag_s1.region <= region_c;
			k_s1          <= k_c;
			f_s1          <= f_c;
			n_s1          <= n_c;
			pos_s1        <= pos_c;
		end
		if (rdy_s2 && valid_s1) begin
			tag_s2  <= tag_s1;
			used_s2 <= NUM_W'(kn_c) + NUM_W'(pos_s1);
			den_s2  <= NUM_W'(fn_c);
		end
		if (rdy_s3 && valid_s2) begin
			tag_s3 <= tag_s2;
			num_s3 <= num_c;
			den_s3 <= den_s2;
			sat_s3 <= sat_c;
		end
	end

	assign out_valid    = valid_s3;
	assign out_data.tag = tag_s3;
	assign out_data.sat = sat_s3;
	assign out_data.num = num_s3;
	assign out_data.den = den_s3;

endmodule

/* src/afe_div.sv */
// ----------------------------------------------------------------------------
// Audio fade envelope gain divider
// Restoring divider that produces one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module afe_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  afe_pkg::afe_div_in_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output afe_pkg::afe_div_out_t  out_data
);
	import afe_pkg::*;

	localparam int STAGES = GAIN_FRAC_BITS;

	logic                      valid_s [STAGES];
	logic                      rdy     [STAGES];
	afe_tag_t                  tag_s   [STAGES];
	logic                      sat_s   [STAGES];
	logic [NUM_W-1:0]          rem_s   [STAGES];
	logic [NUM_W-1:0]          den_s   [STAGES];
	logic [GAIN_FRAC_BITS-1:0] quot_s  [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic                      valid_p, rdy_n, sat_p, ge;
		afe_tag_t                  tag_p;
		logic [NUM_W-1:0]          rem_p, den_p;
		logic [GAIN_FRAC_BITS-1:0] quot_p;
		logic [NUM_W:0]            r2;

		if (i == 0) begin : g_first
			assign valid_p = in_valid;
			assign tag_p   = in_data.tag;
			assign sat_p   = in_data.sat;
			assign rem_p   = in_data.num;
			assign den_p   = in_data.den;
			assign quot_p  = '0;
		end else begin : g_next
			assign valid_p = valid_s[i-1];
			assign tag_p   = tag_s[i-1];
			assign sat_p   = sat_s[i-1];
			assign rem_p   = rem_s[i-1];
			assign den_p   = den_s[i-1];
			assign quot_p  = quot_s[i-1];
		end

		if (i == STAGES - 1) begin : g_last
			assign rdy_n = out_ready;
		end else begin : g_mid
			assign rdy_n = rdy[i+1];
		end

		assign rdy[i] = !valid_s[i] || rdy_n;
		assign r2     = {rem_p, 1'b0};
		assign ge     = (r2 >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				valid_s[i] <= valid_p;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && valid_p) begin
				tag_s[i]  <= tag_p;
				sat_s[i]  <= sat_p;
				den_s[i]  <= den_p;
				rem_s[i]  <= ge ? NUM_W'(r2 - {1'b0, den_p}) : r2[NUM_W-1:0];
				quot_s[i] <= {quot_p[GAIN_FRAC_BITS-2:0], ge};
			end
		end
	end

	assign in_ready      = rdy[0];
	assign out_valid     = valid_s[STAGES-1];
	assign out_data.tag  = tag_s[STAGES-1];
	assign out_data.sat  = sat_s[STAGES-1];
	assign out_data.quot = quot_s[STAGES-1];

	a_num_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.sat &&
		(in_data.tag.region == REGION_FADE_IN || in_data.tag.region == REGION_FADE_OUT)
		|-> in_data.num < in_data.den)
		else $error("Unsaturated fade item enters the divider with num not below den.");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[STAGES-1] && !sat_s[STAGES-1] &&
		(tag_s[STAGES-1].region == REGION_FADE_IN ||
		 tag_s[STAGES-1].region == REGION_FADE_OUT)
		|-> rem_s[STAGES-1] < den_s[STAGES-1])
		else $error("Divider remainder is not below the divisor.");

endmodule

/* src/afe_scale.sv */
// ----------------------------------------------------------------------------
// Audio fade envelope scaler
// Selects the gain for each item's region, multiplies the sample magnitude
// and restores the sign in the output register.
// ----------------------------------------------------------------------------
module afe_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  afe_pkg::afe_div_out_t                in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [afe_pkg::SAMPLE_W-1:0]  sample_out,
	output logic [2:0]                           region
);
	import afe_pkg::*;

	logic [GAIN_W-1:0]          gain_c;
	logic                       neg_c;
	logic [SAMPLE_W-1:0]        mag_c;
	logic [SAMPLE_W+GAIN_W-1:0] prod_c;
	logic [SAMPLE_W-1:0]        res_c, scaled_c;

	logic                       valid_s1, valid_s2, rdy_s1, rdy_s2;
	afe_tag_t                   tag_s1, tag_s2;
	logic                       neg_s1;
	logic [SAMPLE_W+GAIN_W-1:0] prod_s1;
	logic [SAMPLE_W-1:0]        out_s2;

	always_comb begin
		case (in_data.tag.region) inside
			REGION_MUTED: gain_c = GAIN_ZERO;
			REGION_FADE_IN, REGION_FADE_OUT:
				gain_c = in_data.sat ? GAIN_ONE : {1'b0, in_data.quot};
			default: gain_c = GAIN_ONE;
		endcase
	end

	assign neg_c    = in_data.tag.sample[SAMPLE_W-1];
	assign mag_c    = neg_c ? SAMPLE_W'(-in_data.tag.sample) : in_data.tag.sample;
	assign prod_c   = mag_c * gain_c;
	assign res_c    = prod_s1[GAIN_FRAC_BITS +: SAMPLE_W];
	assign scaled_c = neg_s1 ? SAMPLE_W'(-res_c) : res_c;

	assign rdy_s2   = !valid_s2 || out_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			tag_s1  <= in_data.tag;
			neg_s1  <= neg_c;
			prod_s1 <= prod_c;
		end
		if (rdy_s2 && valid_s1) begin
			tag_s2 <= tag_s1;
			out_s2 <= scaled_c;
		end
	end

	assign out_valid  = valid_s2;
	assign sample_out = out_s2;
	assign region     = tag_s2.region;

	a_muted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && tag_s2.region == REGION_MUTED |-> out_s2 == '0)
		else $error("Muted item leaves with a nonzero sample.");

	a_pass_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (tag_s2.region == REGION_OUTSIDE || tag_s2.region == REGION_UNITY)
		|-> out_s2 == tag_s2.sample)
		else $error("Unity or unselected item leaves altered.");

	a_fade_sign: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_s2 != '0 &&
		(tag_s2.region == REGION_FADE_IN || tag_s2.region == REGION_FADE_OUT)
		|-> out_s2[SAMPLE_W-1] == tag_s2.sample[SAMPLE_W-1])
		else $error("Faded item changes sign.");

endmodule

/* bench/audio_fade_envelope_unit_tb.sv */
// ----------------------------------------------------------------------------
// Audio fade envelope unit testbench
// Writes the fade registers over APB and streams tagged audio samples through
// the unit. A predictor of the fade envelope computes the expected sample and
// region of each accepted item with no expectation in the table. Results are
// compared in order against these expectations. A short table of directed
// items covers the extremes and special cases, then random settings and random
// items. The sender and the receiver pause at random, and the receiver once
// holds off for a long stretch so the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module audio_fade_envelope_unit_tb;
	import afe_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int ITEMS_PER_SET   = 110;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		region_t                    region;
	} fade_result_t;

	typedef struct {
		bit                    cfg_row;
		reg_idx_t              idx;
		logic [APB_DW-1:0]     value;
		logic [FRAME_BITS-1:0] frame;
		logic [POS_W-1:0]      pos;
		logic [POS_W-1:0]      count;
		logic [SAMPLE_W-1:0]   sample;
		bit                    known;
		fade_result_t          expected;
	} fade_vector_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [APB_AW-1:0]          paddr = '0;
	logic [APB_DW-1:0]          pwdata = '0;
	logic [APB_DW-1:0]          prdata;
	logic                       pready;
	logic                       item_valid = 1'b0;
	logic                       item_ready;
	logic [FRAME_BITS-1:0]      frame_number = '0;
	logic [POS_W-1:0]           sample_position = '0;
	logic [POS_W-1:0]           samples_per_frame = '0;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       result_valid;
	logic                       result_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic [2:0]                 region;

	logic [FRAME_BITS-1:0] sel_start_q = '0;
	logic [FRAME_BITS-1:0] sel_end_q = '0;
	logic [LEN_W-1:0]      fade_in_q = '0;
	logic [LEN_W-1:0]      fade_out_q = '0;
	logic [LEN_W-1:0]      head_q = '0;
	logic [LEN_W-1:0]      tail_q = '0;

	fade_result_t expected_samples[$];
	fade_vector_t directed_table[$];
	bit           cur_known = 1'b0;
	fade_result_t cur_expected = '0;
	int           mismatches = 0;
	int           tx_idle_pct = 0;
	int           rx_idle_pct = 0;
	int           hold_token = 0;
	int           hold_seen = 0;
	int           hold_left = 0;

	audio_fade_envelope_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.item_valid        (item_valid),
		.item_ready        (item_ready),
		.frame_number      (frame_number),
		.sample_position   (sample_position),
		.samples_per_frame (samples_per_frame),
		.sample_in         (sample_in),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.sample_out        (sample_out),
		.region            (region)
	);

	always #1 clk = ~clk;

	function automatic longint gain_of(longint num, longint den);
		longint g;
		longint one;
		one = longint'(1) << GAIN_FRAC_BITS;
		g = (num << GAIN_FRAC_BITS) / den;
		return (g > one) ? one : g;
	endfunction

	function automatic fade_result_t fade_envelope(logic [FRAME_BITS-1:0] frame,
			logic [POS_W-1:0] pos_in, logic [POS_W-1:0] count_in,
			logic signed [SAMPLE_W-1:0] s);
		longint fr, st, en, hd, tl, fi, fo, fst, fed, n, pos, q, num, den, g, mag, prod;
		fade_result_t r;
		fr = frame;
		st = sel_start_q;
		en = sel_end_q;
		hd = head_q;
		tl = tail_q;
		fi = fade_in_q;
		fo = fade_out_q;
		n = count_in;
		pos = pos_in;
		g = -1;
		if (n == 0) begin
			n = 1;
			pos = 0;
		end
		r.sample = s;
		r.region = REGION_OUTSIDE;
		if (fr < st || fr > en)
			return r;
		fst = st + hd;
		fed = en - tl;
		if (fr < fst || fr > fed) begin
			r.sample = '0;
			r.region = REGION_MUTED;
		end else if (fr - fst < fi) begin
			r.region = REGION_FADE_IN;
			g = gain_of((fr - fst) * n + pos, fi * n);
		end else if (fed - fr < fo) begin
			r.region = REGION_FADE_OUT;
			q = fo - 1 - (fed - fr);
			den = fo * n;
			num = q * n + pos;
			g = (num >= den) ? 0 : gain_of(den - num, den);
		end else begin
			r.region = REGION_UNITY;
		end
		if (g >= 0) begin
			mag = (s < 0) ? -longint'(s) : longint'(s);
			prod = (mag * g) >>> GAIN_FRAC_BITS;
			r.sample = SAMPLE_W'((s < 0) ? -prod : prod);
		end
		return r;
	endfunction

	function automatic fade_vector_t item_vector(logic [FRAME_BITS-1:0] f, logic [POS_W-1:0] p,
			logic [POS_W-1:0] n, logic [SAMPLE_W-1:0] s);
		fade_vector_t v;
		v.cfg_row = 1'b0;
		v.idx = REG_SELECT_START;
		v.value = '0;
		v.frame = f;
		v.pos = p;
		v.count = n;
		v.sample = s;
		v.known = 1'b0;
		v.expected = '0;
		return v;
	endfunction

	function automatic fade_vector_t known_vector(logic [FRAME_BITS-1:0] f,
			logic [POS_W-1:0] p, logic [POS_W-1:0] n, logic [SAMPLE_W-1:0] s,
			logic [SAMPLE_W-1:0] exp_sample, region_t exp_region);
		fade_vector_t v;
		v = item_vector(f, p, n, s);
		v.known = 1'b1;
		v.expected.sample = exp_sample;
		v.expected.region = exp_region;
		return v;
	endfunction

	function automatic fade_vector_t cfg_vector(reg_idx_t idx, logic [APB_DW-1:0] value);
		fade_vector_t v;
		v = item_vector('0, '0, 16'd1, '0);
		v.cfg_row = 1'b1;
		v.idx = idx;
		v.value = value;
		return v;
	endfunction

	function automatic int random_length();
		case ($urandom_range(7))
			0: return 0;
			1: return $urandom_range(511, 257);
			2: return 256;
			default: return $urandom_range(64, 1);
		endcase
	endfunction

	task automatic log_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	task automatic send_item(fade_vector_t v);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		frame_number <= v.frame;
		sample_position <= v.pos;
		samples_per_frame <= v.count;
		sample_in <= v.sample;
		cur_known = v.known;
		cur_expected = v.expected;
		do @(posedge clk); while (item_ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic set_register(reg_idx_t idx, logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] readback;
		item_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		case (idx)
			REG_SELECT_START: sel_start_q = value[FRAME_BITS-1:0];
			REG_SELECT_END:   sel_end_q = value[FRAME_BITS-1:0];
			REG_FADE_IN:      fade_in_q = value[LEN_W-1:0];
			REG_FADE_OUT:     fade_out_q = value[LEN_W-1:0];
			REG_SILENT_HEAD:  head_q = value[LEN_W-1:0];
			REG_SILENT_TAIL:  tail_q = value[LEN_W-1:0];
			default: ;
		endcase
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== value)
			log_mismatch($sformatf("register %s read back 0x%08h, expected 0x%08h",
				idx.name(), readback, value));
		@(negedge clk);
	endtask

	// Expectations are queued and results checked in one process, so the order
	// of the two is fixed.
	always @(posedge clk) begin
		fade_result_t exp_r;
		if (item_valid && item_ready)
			expected_samples.push_back(cur_known ? cur_expected :
				fade_envelope(frame_number, sample_position, samples_per_frame, sample_in));
		if (result_valid && result_ready) begin
			if (expected_samples.size() == 0) begin
				log_mismatch($sformatf("unexpected result: sample_out %0d region %0d",
					sample_out, region));
			end else begin
				exp_r = expected_samples.pop_front();
				if (sample_out !== exp_r.sample || region !== exp_r.region)
					log_mismatch($sformatf({"result mismatch: expected sample_out %0d region %0d,",
						" got sample_out %0d region %0d"},
						exp_r.sample, exp_r.region, sample_out, region));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left == 0 && hold_seen != hold_token) begin
			hold_seen = hold_token;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#1000000;
		$display("audio_fade_envelope_unit test failed");
		$finish;
	end

	initial begin
		longint st, en, hd, tl, fin, fout, fr;
		int n, pos;
		logic [SAMPLE_W-1:0] smp;

		directed_table.push_back(known_vector(20'd0, 16'd0, 16'd1, 16'h1234, 16'h1234,
			REGION_UNITY));
		directed_table.push_back(known_vector(20'hFFFFF, 16'd65534, 16'd65535, 16'h8000,
			16'h8000, REGION_OUTSIDE));
		directed_table.push_back(cfg_vector(REG_SELECT_START, 32'd100));
		directed_table.push_back(cfg_vector(REG_SELECT_END, 32'd1000));
		directed_table.push_back(cfg_vector(REG_FADE_IN, 32'd10));
		directed_table.push_back(cfg_vector(REG_FADE_OUT, 32'd20));
		directed_table.push_back(cfg_vector(REG_SILENT_HEAD, 32'd5));
		directed_table.push_back(cfg_vector(REG_SILENT_TAIL, 32'd7));
		directed_table.push_back(known_vector(20'd99, 16'd0, 16'd100, 16'h7FFF, 16'h7FFF,
			REGION_OUTSIDE));
		directed_table.push_back(known_vector(20'd1001, 16'd0, 16'd100, 16'h8000, 16'h8000,
			REGION_OUTSIDE));
		directed_table.push_back(known_vector(20'd100, 16'd0, 16'd100, 16'h7FFF, 16'h0000,
			REGION_MUTED));
		directed_table.push_back(known_vector(20'd104, 16'd99, 16'd100, 16'h8000, 16'h0000,
			REGION_MUTED));
		directed_table.push_back(known_vector(20'd994, 16'd0, 16'd100, 16'h8001, 16'h0000,
			REGION_MUTED));
		directed_table.push_back(known_vector(20'd105, 16'd0, 16'd100, 16'h7FFF, 16'h0000,
			REGION_FADE_IN));
		directed_table.push_back(known_vector(20'd115, 16'd3, 16'd100, 16'h8000, 16'h8000,
			REGION_UNITY));
		directed_table.push_back(item_vector(20'd107, 16'd50, 16'd100, 16'h7FFF));
		directed_table.push_back(item_vector(20'd107, 16'd50, 16'd100, 16'h8000));
		directed_table.push_back(item_vector(20'd110, 16'd1, 16'd3, 16'hFFFF));
		directed_table.push_back(item_vector(20'd107, 16'd1234, 16'd0, 16'h4000));
		directed_table.push_back(item_vector(20'd114, 16'd65534, 16'd1, 16'h8000));
		directed_table.push_back(item_vector(20'd974, 16'd0, 16'd65535, 16'h7FFF));
		directed_table.push_back(item_vector(20'd993, 16'd99, 16'd100, 16'h8000));
		directed_table.push_back(known_vector(20'd993, 16'd65534, 16'd10, 16'h7FFF, 16'h0000,
			REGION_FADE_OUT));
		directed_table.push_back(cfg_vector(REG_SELECT_START, 32'd500));
		directed_table.push_back(cfg_vector(REG_SELECT_END, 32'd400));
		directed_table.push_back(known_vector(20'd450, 16'd0, 16'd100, 16'h5555, 16'h5555,
			REGION_OUTSIDE));
		directed_table.push_back(cfg_vector(REG_SELECT_START, 32'd0));
		directed_table.push_back(cfg_vector(REG_SELECT_END, 32'd300));
		directed_table.push_back(cfg_vector(REG_FADE_IN, 32'd511));
		directed_table.push_back(cfg_vector(REG_FADE_OUT, 32'd511));
		directed_table.push_back(cfg_vector(REG_SILENT_HEAD, 32'd256));
		directed_table.push_back(cfg_vector(REG_SILENT_TAIL, 32'd256));
		directed_table.push_back(known_vector(20'd0, 16'd0, 16'd100, 16'h7FFF, 16'h0000,
			REGION_MUTED));
		directed_table.push_back(known_vector(20'd300, 16'd0, 16'd100, 16'h8000, 16'h0000,
			REGION_MUTED));
		directed_table.push_back(known_vector(20'd150, 16'd7, 16'd100, 16'h1111, 16'h0000,
			REGION_MUTED));
		directed_table.push_back(cfg_vector(REG_SELECT_END, 32'hFFFFF));
		directed_table.push_back(cfg_vector(REG_SILENT_HEAD, 32'd0));
		directed_table.push_back(cfg_vector(REG_SILENT_TAIL, 32'd0));
		directed_table.push_back(item_vector(20'd0, 16'd0, 16'd65535, 16'h7FFF));
		directed_table.push_back(item_vector(20'd510, 16'd65534, 16'd65535, 16'h8000));
		directed_table.push_back(item_vector(20'hFFFFF, 16'd65534, 16'd65535, 16'h7FFF));
		directed_table.push_back(item_vector(20'd1048000, 16'd12345, 16'd4800, 16'h1357));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_table[i]) begin
			if (directed_table[i].cfg_row)
				set_register(directed_table[i].idx, directed_table[i].value);
			else
				send_item(directed_table[i]);
		end

		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 66 : 0;
			rx_idle_pct <= (mode == 0) ? 66 : (mode == 1) ? 37 : 0;
			for (int set = 0; set < 3; set++) begin
				st = ($urandom_range(3) == 0) ? $urandom_range(20'hFFFFF) : $urandom_range(3000);
				case ($urandom_range(7))
					0: en = st - 1 - $urandom_range(50);
					1: en = 20'hFFFFF;
					default: en = st + $urandom_range(4000);
				endcase
				if (en > 20'hFFFFF)
					en = 20'hFFFFF;
				if (en < 0)
					en = 0;
				fin = random_length();
				fout = random_length();
				hd = random_length();
				tl = random_length();
				set_register(REG_SELECT_START, APB_DW'(st));
				set_register(REG_SELECT_END, APB_DW'(en));
				set_register(REG_FADE_IN, APB_DW'(fin));
				set_register(REG_FADE_OUT, APB_DW'(fout));
				set_register(REG_SILENT_HEAD, APB_DW'(hd));
				set_register(REG_SILENT_TAIL, APB_DW'(tl));
				if (mode == 2 && set == 0)
					hold_token <= hold_token + 1;
				for (int k = 0; k < ITEMS_PER_SET; k++) begin
					case ($urandom_range(9))
						0: fr = $urandom_range(20'hFFFFF);
						1, 2: fr = st + hd - 2 + $urandom_range(fin + 4);
						3, 4: fr = en - tl + 2 - $urandom_range(fout + 4);
						5: fr = st - 2 + $urandom_range(hd + 4);
						6: fr = en + 2 - $urandom_range(tl + 4);
						default: fr = st + $urandom_range((en >= st) ? en - st : 0);
					endcase
					case ($urandom_range(9))
						0: n = 0;
						1: n = 65535;
						2: n = $urandom_range(65535);
						default: n = $urandom_range(2000, 1);
					endcase
					if (n > 1 && $urandom_range(7) != 0)
						pos = $urandom_range(n - 1);
					else
						pos = $urandom_range(65534);
					case ($urandom_range(9))
						0: smp = 16'h8000;
						1: smp = 16'h7FFF;
						default: smp = SAMPLE_W'($urandom_range(16'hFFFF));
					endcase
					send_item(item_vector(FRAME_BITS'(fr), POS_W'(pos), POS_W'(n), smp));
				end
			end
		end

		item_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("audio_fade_envelope_unit test passed");
		else
			$display("audio_fade_envelope_unit test failed");
		$finish;
	end

endmodule

/* filelist.f */
src/afe_pkg.sv
src/afe_front.sv
src/afe_div.sv
src/afe_scale.sv
src/audio_fade_envelope_unit.sv
bench/audio_fade_envelope_unit_tb.sv
